/* rtl/lru_pkg.sv */
// Shared types and constants for the LRU page replacement unit.
// Holds the payload structs, the cell-chain probe and update records and the
// controller state encoding. No dependencies.
package lru_pkg;

    localparam int PAGE_W = 16;   // page field width on the ports
    localparam int SLOT_W = 4;    // slot field width on the ports
    localparam int CNT_W  = 32;   // stamps, use counter and fault total
    localparam int CFG_W  = 5;    // frame_count register width
    localparam int IDX_W  = 6;    // frame index width, covers the largest build
    localparam int CMP_W  = 7;    // width for comparing frame counts

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = CFG_W'(4);
    localparam logic [CNT_W-1:0] CNT_MAX         = '1;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              new_run;
    } t_in;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  fault_count;
    } t_out;

    // Search record handed from cell to cell, one hop per cycle.
    typedef struct packed {
        logic              active;
        logic [PAGE_W-1:0] page;
        logic              hit_found;
        logic [IDX_W-1:0]  hit_idx;
        logic [CNT_W-1:0]  min_stamp;
        logic [IDX_W-1:0]  min_idx;
    } t_probe;

    // Write broadcast from the controller to the frame cells.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [PAGE_W-1:0] page;
        logic [CNT_W-1:0]  stamp;
    } t_update;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_SEARCH,
        S_COMMIT
    } t_state;

endpackage

/* rtl/lru_cell.sv */
// One frame of the LRU unit: page number, valid mark and last-use stamp, plus
// one stage of the search chain. Depends on lru_pkg.
module lru_cell #(
    parameter int CELL_IDX = 0,
    parameter int PG_W     = 16,
    parameter int N_W      = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [N_W-1:0]       i_frames_used,
    input  logic                 i_clear,
    input  lru_pkg::t_update     i_upd,
    input  lru_pkg::t_probe      i_probe,
    output lru_pkg::t_probe      o_probe
);

    logic [PG_W-1:0]         r_page;
    logic                    r_valid;
    logic [lru_pkg::CNT_W-1:0] r_stamp;
    lru_pkg::t_probe         r_probe;
    lru_pkg::t_probe         n_probe;

    logic w_in_use;
    logic w_match;

    assign w_in_use = (N_W'(CELL_IDX) < i_frames_used);
    assign w_match  = w_in_use && r_valid && (r_page == i_probe.page[PG_W-1:0]);

    // The first matching frame wins the hit; a strictly smaller stamp takes the
    // minimum, so ties stay with the lower index seen earlier in the chain.
    always_comb begin
        n_probe = i_probe;
        if (w_match && !i_probe.hit_found) begin
            n_probe.hit_found = 1'b1;
            n_probe.hit_idx   = lru_pkg::IDX_W'(CELL_IDX);
        end
        if (w_in_use && (r_stamp < i_probe.min_stamp)) begin
            n_probe.min_stamp = r_stamp;
            n_probe.min_idx   = lru_pkg::IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_stamp <= '0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
            r_stamp <= '0;
        end else if (i_upd.en && (i_upd.idx == lru_pkg::IDX_W'(CELL_IDX))) begin
            r_valid <= 1'b1;
            r_stamp <= i_upd.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en && (i_upd.idx == lru_pkg::IDX_W'(CELL_IDX))) begin
            r_page <= i_upd.page[PG_W-1:0];
        end
    end

    assign o_probe = r_probe;

endmodule

/* rtl/lru_page_replacement_unit.sv */
// LRU page replacement unit: controller plus a chain of FRAMES lru_cell frames.
// Depends on lru_pkg. A reference is answered once its search record has walked
// the chain one frame per cycle to the tail and the chosen frame is committed.
// A new reference is taken only after the last one is committed; a finished
// result may wait in the output register while the next reference is taken.
// Reset (i_rst_n, synchronous): frames invalid, stamps and counters zero, count 4.
module lru_page_replacement_unit #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [lru_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  lru_pkg::t_in             i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output lru_pkg::t_out            o_out
);

    // Stored page width: the input field never carries more than PAGE_W bits.
    localparam int PG_W = (PAGE_BITS < lru_pkg::PAGE_W) ? PAGE_BITS : lru_pkg::PAGE_W;
    localparam int N_W  = $clog2(FRAMES + 1);

    function automatic logic [lru_pkg::CNT_W-1:0] sat_inc(
        input logic [lru_pkg::CNT_W-1:0] v
    );
        return (v == lru_pkg::CNT_MAX) ? v : v + lru_pkg::CNT_W'(1);
    endfunction

    lru_pkg::t_state r_state;
    lru_pkg::t_state n_state;

    logic [lru_pkg::CFG_W-1:0] r_frame_count;
    logic [PG_W-1:0]           r_page;
    logic [lru_pkg::CNT_W-1:0] r_use_cnt;
    logic [lru_pkg::CNT_W-1:0] r_fault;
    lru_pkg::t_probe           r_tail;
    logic                      r_out_valid;
    lru_pkg::t_out             r_out;

    logic                      w_in_accept;
    logic                      w_clear;
    logic                      w_capture;
    logic                      w_commit;
    logic [N_W-1:0]            w_frames_used;
    logic [lru_pkg::IDX_W-1:0] w_pos;
    logic [lru_pkg::CNT_W-1:0] w_stamp;
    logic [lru_pkg::CNT_W-1:0] w_fault_next;
    lru_pkg::t_update          w_upd;
    lru_pkg::t_probe           w_probe [0:FRAMES];

    // The configuration register can be written at any time; the host must
    // write it only while no transaction is in flight, the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= lru_pkg::FRAME_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frame_count <= i_cfg_data;
        end
    end

    // A count of zero behaves as one frame, and a count beyond the built
    // capacity is clamped to it.
    always_comb begin
        if (r_frame_count == '0) begin
            w_frames_used = N_W'(1);
        end else if (lru_pkg::CMP_W'(r_frame_count) > lru_pkg::CMP_W'(FRAMES)) begin
            w_frames_used = N_W'(FRAMES);
        end else begin
            w_frames_used = N_W'(r_frame_count);
        end
    end

    // Sequencer: take a reference, launch a search record into the chain,
    // wait for it at the tail, then write the chosen frame and the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lru_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_capture  = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            lru_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = lru_pkg::S_LAUNCH;
                end
            end
            lru_pkg::S_LAUNCH: begin
                n_state = lru_pkg::S_SEARCH;
            end
            lru_pkg::S_SEARCH: begin
                if (w_probe[FRAMES].active) begin
                    w_capture = 1'b1;
                    n_state   = lru_pkg::S_COMMIT;
                end
            end
            lru_pkg::S_COMMIT: begin
                // The result register must be free, or emptied in this cycle.
                if (!r_out_valid || i_out_ready) begin
                    w_commit = 1'b1;
                    n_state  = lru_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lru_pkg::S_IDLE;
            end
        endcase
    end

    assign w_in_accept = i_in_valid && o_in_ready;

    // A new run wipes valid marks and stamps in every cell at the accepting
    // edge, so the search that follows already sees the cleared frames.
    assign w_clear = w_in_accept && i_in.new_run;

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_page <= i_in.page[PG_W-1:0];
        end
        if (w_capture) begin
            r_tail <= w_probe[FRAMES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_cnt <= '0;
            r_fault   <= '0;
        end else if (w_clear) begin
            r_use_cnt <= '0;
            r_fault   <= '0;
        end else if (w_commit) begin
            r_use_cnt <= w_stamp;
            r_fault   <= w_fault_next;
        end
    end

    // The search record enters the head of the chain for one cycle. A minimum
    // seeded at the largest stamp with index zero makes frame zero the victim
    // when every stamp in use is saturated.
    always_comb begin
        w_probe[0]           = '0;
        w_probe[0].active    = (r_state == lru_pkg::S_LAUNCH);
        w_probe[0].page      = lru_pkg::PAGE_W'(r_page);
        w_probe[0].min_stamp = lru_pkg::CNT_MAX;
    end

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        lru_cell #(
            .CELL_IDX (g),
            .PG_W     (PG_W),
            .N_W      (N_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_frames_used (w_frames_used),
            .i_clear       (w_clear),
            .i_upd         (w_upd),
            .i_probe       (w_probe[g]),
            .o_probe       (w_probe[g+1])
        );
    end

    // A hit refreshes the matching frame; a miss replaces the least recently
    // used frame in use and counts a fault. Both take the next stamp.
    assign w_pos        = r_tail.hit_found ? r_tail.hit_idx : r_tail.min_idx;
    assign w_stamp      = sat_inc(r_use_cnt);
    assign w_fault_next = r_tail.hit_found ? r_fault : sat_inc(r_fault);

    always_comb begin
        w_upd       = '0;
        w_upd.en    = w_commit;
        w_upd.idx   = w_pos;
        w_upd.page  = lru_pkg::PAGE_W'(r_page);
        w_upd.stamp = w_stamp;
    end

    // Output register: holds one result until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out.hit         <= r_tail.hit_found;
            r_out.slot        <= lru_pkg::SLOT_W'(w_pos);
            r_out.fault_count <= w_fault_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A search record reaches the tail of the chain only while it is awaited.
    a_tail_in_search : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_probe[FRAMES].active |-> (r_state == lru_pkg::S_SEARCH))
        else $error("search record left the chain outside the search phase");

    // The frame written always lies among the frames in use.
    a_pos_in_use : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> (lru_pkg::CMP_W'(w_pos) < lru_pkg::CMP_W'(w_frames_used)))
        else $error("chosen frame is outside the frames in use");

    // After a fault the running fault total can never read zero, and the result is presented.
    a_fault_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && !r_tail.hit_found) |=> (r_fault != '0) && o_out_valid)
        else $error("fault not counted or result not presented");

endmodule

/* dv/lru_scoreboard.sv */
// Scoreboard for the LRU page replacement unit: a replacement predictor that
// keeps its own frame table and a queue of predicted outcomes.
// Depends on lru_pkg for the payload structs and field widths.
`timescale 1ns / 100ps

package lru_tb_pkg;

    localparam int FRAME_CAP = 16;

    class lru_scoreboard;
        logic [lru_pkg::PAGE_W-1:0] frame_page [FRAME_CAP];
        bit                         frame_valid[FRAME_CAP];
        logic [lru_pkg::CNT_W-1:0]  last_use   [FRAME_CAP];
        logic [lru_pkg::CNT_W-1:0]  use_counter;
        logic [lru_pkg::CNT_W-1:0]  fault_total;
        logic [lru_pkg::CFG_W-1:0]  frame_count;
        lru_pkg::t_out              predicted_outcomes[$];
        int                         errors;

        function new();
            for (int i = 0; i < FRAME_CAP; i++) begin
                frame_page[i] = '0;
            end
            clear_run();
            frame_count = lru_pkg::FRAME_COUNT_RST;
            errors      = 0;
        endfunction

        function void clear_run();
            for (int i = 0; i < FRAME_CAP; i++) begin
                frame_valid[i] = 1'b0;
                last_use[i]    = '0;
            end
            use_counter = '0;
            fault_total = '0;
        endfunction

        function void write_frame_count(input logic [lru_pkg::CFG_W-1:0] value);
            frame_count = value;
        endfunction

        // The use counter sticks at its maximum, so late stamps tie.
        function logic [lru_pkg::CNT_W-1:0] next_stamp();
            if (use_counter != lru_pkg::CNT_MAX) begin
                use_counter++;
            end
            return use_counter;
        endfunction

        function int pending();
            return predicted_outcomes.size();
        endfunction

        function void note_reference(input lru_pkg::t_in req);
            int            frames_used;
            int            pos;
            bit            found;
            lru_pkg::t_out outcome;
            if (req.new_run) begin
                clear_run();
            end
            if (frame_count == 0) begin
                frames_used = 1;
            end else if (frame_count > FRAME_CAP) begin
                frames_used = FRAME_CAP;
            end else begin
                frames_used = frame_count;
            end
            found = 1'b0;
            pos   = 0;
            for (int i = 0; i < frames_used; i++) begin
                if (!found && frame_valid[i] && frame_page[i] == req.page) begin
                    pos   = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                last_use[pos] = next_stamp();
            end else begin
                // Oldest stamp loses; strict compare keeps the lowest index on ties.
                for (int i = 1; i < frames_used; i++) begin
                    if (last_use[i] < last_use[pos]) begin
                        pos = i;
                    end
                end
                frame_page[pos]  = req.page;
                frame_valid[pos] = 1'b1;
                last_use[pos]    = next_stamp();
                if (fault_total != lru_pkg::CNT_MAX) begin
                    fault_total++;
                end
            end
            outcome.hit         = found;
            outcome.slot        = lru_pkg::SLOT_W'(pos);
            outcome.fault_count = fault_total;
            predicted_outcomes.push_back(outcome);
        endfunction

        function void check_outcome(input lru_pkg::t_out got);
            lru_pkg::t_out want;
            if (predicted_outcomes.size() == 0) begin
                $error({"output transaction with no reference outstanding: ",
                        "hit=%0d slot=%0d fault_count=%0d"},
                       got.hit, got.slot, got.fault_count);
                errors++;
                return;
            end
            want = predicted_outcomes.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                errors++;
            end
            if (got.slot !== want.slot) begin
                $error("slot: expected %0d, actual %0d", want.slot, got.slot);
                errors++;
            end
            if (got.fault_count !== want.fault_count) begin
                $error("fault_count: expected %0d, actual %0d",
                       want.fault_count, got.fault_count);
                errors++;
            end
        endfunction
    endclass

endpackage

/* dv/testbench.sv */
// Top-level testbench for lru_page_replacement_unit: directed and random page
// references with random pacing on both channels, checked by lru_scoreboard.
// Depends on lru_pkg, lru_tb_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module testbench;

    // The unit walks its search record through one cell per cycle, so the
    // wait for one search is sized from the depth of the chain.
    localparam int LATENCY       = lru_tb_pkg::FRAME_CAP + 2;
    localparam int SETTLE_CYCLES = 2 * LATENCY;
    // Longest quiet stretch that a correct run can show is a long stall on
    // either side plus one search, far below this limit.
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 225;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [lru_pkg::CFG_W-1:0] i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    lru_pkg::t_in              i_in;
    logic                      o_out_valid;
    logic                      i_out_ready;
    lru_pkg::t_out             o_out;

    // When cleared, the corresponding side runs without any idle cycles.
    bit                        pace_source;
    bit                        pace_sink;

    lru_tb_pkg::lru_scoreboard sb;

    lru_page_replacement_unit #(
        .FRAMES    (lru_tb_pkg::FRAME_CAP),
        .PAGE_BITS (lru_pkg::PAGE_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int draw_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offers one reference transaction and returns at the falling edge after
    // it was accepted, with valid still high. The next call either lowers
    // valid for a gap or presents the next payload, never both in one step.
    task automatic send_reference(input logic [lru_pkg::PAGE_W-1:0] page,
                                  input logic new_run);
        int           gap;
        lru_pkg::t_in req;
        req.page    = page;
        req.new_run = new_run;
        gap = pace_source ? draw_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_reference(req);
        @(negedge i_clk);
    endtask

    // Parks the sender until every predicted outcome has been returned, then
    // lets one search latency pass so that the unit is surely idle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // Register writes happen only with the unit idle.
    task automatic write_frame_count(input logic [lru_pkg::CFG_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_frame_count(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Most references come from a small working set near the frame count, so
    // that hits, LRU evictions and thrashing all happen; the rest are spread
    // over the whole page range and toggle every page bit.
    task automatic run_random_phase(input logic [lru_pkg::CFG_W-1:0] count,
                                    input bit paced);
        int                         frames_used;
        int                         set_size;
        int                         pick;
        logic [lru_pkg::PAGE_W-1:0] base;
        logic [lru_pkg::PAGE_W-1:0] page;
        logic                       new_run;
        write_frame_count(count);
        pace_source = paced;
        pace_sink   = paced;
        if (count == 0) begin
            frames_used = 1;
        end else if (count > lru_tb_pkg::FRAME_CAP) begin
            frames_used = lru_tb_pkg::FRAME_CAP;
        end else begin
            frames_used = count;
        end
        base     = lru_pkg::PAGE_W'($urandom);
        set_size = $urandom_range(1, frames_used + 3);
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                base     = lru_pkg::PAGE_W'($urandom);
                set_size = $urandom_range(1, frames_used + 3);
            end
            if (pick < 80) begin
                page = base + lru_pkg::PAGE_W'($urandom_range(0, set_size - 1));
            end else begin
                page = lru_pkg::PAGE_W'($urandom);
            end
            new_run = (k == 0 && $urandom_range(0, 1) == 1) || ($urandom_range(0, 99) < 2);
            send_reference(page, new_run);
        end
    endtask

    // Output side: ready toggles with random run lengths, or stays high
    // while sink pacing is off.
    initial begin : sink_pacing
        int hold;
        hold        = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!pace_sink) begin
                i_out_ready <= 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else begin
                i_out_ready <= !i_out_ready;
                hold = draw_gap();
            end
        end
    end

    // Every accepted output transaction is checked against the oldest
    // predicted outcome.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_outcome(o_out);
        end
    end

    // Ends the run if no transaction is accepted on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        logic [lru_pkg::CFG_W-1:0] count;
        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        pace_source = 1'b1;
        pace_sink   = 1'b1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default of four frames: empty frames fill in index order, a hit
        // refreshes its stamp, and the least recently used frame is evicted.
        send_reference(16'h0000, 1'b1);
        send_reference(16'hFFFF, 1'b0);
        send_reference(16'h0000, 1'b0);
        send_reference(16'h1234, 1'b0);
        send_reference(16'h5678, 1'b0);
        send_reference(16'hABCD, 1'b0);
        send_reference(16'hFFFF, 1'b0);
        // A new run leaves old pages in place but invalid, so they miss.
        send_reference(16'h0000, 1'b1);
        send_reference(16'h1234, 1'b0);

        // A frame count of zero behaves as a single frame.
        write_frame_count(5'd0);
        send_reference(16'h0007, 1'b0);
        send_reference(16'h0007, 1'b0);
        send_reference(16'h0008, 1'b0);

        // Counts above the frame capacity saturate to it.
        write_frame_count(5'd31);
        send_reference(16'hFFFF, 1'b1);
        send_reference(16'h8000, 1'b0);
        send_reference(16'hFFFF, 1'b0);

        // Frames beyond a shrunken count are ignored but keep their pages,
        // so the page parked in frame two hits again once the count grows.
        write_frame_count(5'd8);
        send_reference(16'h4000, 1'b0);
        write_frame_count(5'd2);
        send_reference(16'h2000, 1'b0);
        write_frame_count(5'd16);
        send_reference(16'h4000, 1'b0);

        // Random phases, each under its own frame count; the third one runs
        // without idle cycles on either side.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    count = 5'd1;
                end
                1: begin
                    count = 5'd16;
                end
                3: begin
                    count = 5'd0;
                end
                5: begin
                    count = 5'd31;
                end
                default: begin
                    count = lru_pkg::CFG_W'($urandom_range(0, 31));
                end
            endcase
            run_random_phase(count, p != 2);
        end
        pace_source = 1'b1;
        pace_sink   = 1'b1;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* lru_page_replacement_unit.f */
rtl/lru_pkg.sv
rtl/lru_cell.sv
rtl/lru_page_replacement_unit.sv
dv/lru_scoreboard.sv
dv/testbench.sv
